FILE: rtl/core/i2cms_pkg.sv
package i2cms_pkg;

    localparam int unsigned HALF_W    = 16;
    localparam int unsigned PHASE_W   = 5;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ADDR7_W   = 7;
    localparam int unsigned REQ_W     = 3;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [HALF_W-1:0]  HALF_PERIOD_RESET = HALF_W'(40);

    localparam logic [PHASE_W-1:0] BYTE_PHASES      = PHASE_W'(16);
    localparam logic [PHASE_W-1:0] ACK_DRIVE_PHASE  = PHASE_W'(16);
    localparam logic [PHASE_W-1:0] LAST_BYTE_PHASE  = PHASE_W'(17);
    localparam logic [PHASE_W-1:0] RETRY_STOP_PHASE = PHASE_W'(18);
    localparam logic [PHASE_W-1:0] RETRY_SCL_PHASE  = PHASE_W'(19);
    localparam logic [PHASE_W-1:0] RETRY_SDA_PHASE  = PHASE_W'(20);
    localparam logic [PHASE_W-1:0] LAST_RETRY_PHASE = PHASE_W'(21);
    localparam logic [PHASE_W-1:0] LAST_START_PHASE = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] LAST_RSTRT_PHASE = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] LAST_STOP_PHASE  = PHASE_W'(2);

    // register index, taken from paddr[2]
    localparam logic REG_HALF_PERIOD = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 3'd0,
        REQ_START    = 3'd1,
        REQ_REPSTART = 3'd2,
        REQ_STOP     = 3'd3,
        REQ_WRITE    = 3'd4,
        REQ_READ     = 3'd5,
        REQ_ADDR     = 3'd6
    } req_code_t;

    typedef enum logic [6:0] {
        CMD_IDLE     = 7'b0000001,
        CMD_START    = 7'b0000010,
        CMD_REPSTART = 7'b0000100,
        CMD_STOP     = 7'b0001000,
        CMD_WRITE    = 7'b0010000,
        CMD_READ     = 7'b0100000,
        CMD_ADDR     = 7'b1000000
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic               sda_in;
        logic [BYTE_W-1:0]  data_byte;
        logic [ADDR7_W-1:0] target_address;
        logic               read_not_write;
        logic               send_ack;
        logic               retry_on_nack;
    } item_t;

    typedef struct packed {
        logic              scl_low;
        logic              sda_low;
        logic              busy_res;
        logic              done_res;
        logic              nack;
        logic [BYTE_W-1:0] read_data;
        logic              rejected;
    } res_t;

endpackage

FILE: rtl/core/i2cms_ifs.sv
interface i2cms_req_if
    import i2cms_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic               sda_in;
    logic [BYTE_W-1:0]  data_byte;
    logic [ADDR7_W-1:0] target_address;
    logic               read_not_write;
    logic               send_ack;
    logic               retry_on_nack;

    modport source (
        output valid, req_type, sda_in, data_byte, target_address,
               read_not_write, send_ack, retry_on_nack,
        input  ready
    );

    modport sink (
        input  valid, req_type, sda_in, data_byte, target_address,
               read_not_write, send_ack, retry_on_nack,
        output ready
    );
endinterface

interface i2cms_res_if
    import i2cms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              scl_low;
    logic              sda_low;
    logic              busy_res;
    logic              done_res;
    logic              nack;
    logic [BYTE_W-1:0] read_data;
    logic              rejected;

    modport source (
        output valid, scl_low, sda_low, busy_res, done_res, nack, read_data, rejected,
        input  ready
    );

    modport sink (
        input  valid, scl_low, sda_low, busy_res, done_res, nack, read_data, rejected,
        output ready
    );
endinterface

FILE: rtl/core/i2cms_engine.sv
module i2cms_engine
    import i2cms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  item_t             item,
    input  logic [HALF_W-1:0] half_period_ticks,
    output res_t              res_next
);

    cmd_t               cmd_reg, cmd_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [HALF_W-1:0]  tick_reg, tick_next;
    logic               retry_reg, retry_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;

    logic [HALF_W-1:0]  load_val;
    logic [HALF_W-1:0]  tick_dec;
    logic [PHASE_W-1:0] phase_adv;
    logic               busy;
    logic               is_byte_cmd;
    logic               start_phase;
    logic               finish;
    logic [1:0]         drive;

    function automatic logic [PHASE_W-1:0] last_phase(input cmd_t cmd);
        logic [PHASE_W-1:0] lp;
        case (cmd)
            CMD_START:    lp = LAST_START_PHASE;
            CMD_REPSTART: lp = LAST_RSTRT_PHASE;
            CMD_STOP:     lp = LAST_STOP_PHASE;
            default:      lp = LAST_BYTE_PHASE;
        endcase
        return lp;
    endfunction

    // {scl, sda} drivers at the beginning of phase p
    function automatic logic [1:0] phase_drive(
        input cmd_t               cmd,
        input logic [PHASE_W-1:0] p,
        input logic               msb,
        input logic               ack_low,
        input logic               scl_cur,
        input logic               sda_cur
    );
        logic scl;
        logic sda;
        scl = scl_cur;
        sda = sda_cur;
        case (cmd)
            CMD_START:
            begin
                sda = 1'b1;
            end
            CMD_REPSTART:
            begin
                if (p == PHASE_W'(0)) scl = 1'b1;
                else if (p == PHASE_W'(1)) sda = 1'b0;
                else if (p == PHASE_W'(2)) scl = 1'b0;
                else sda = 1'b1;
            end
            CMD_STOP:
            begin
                if (p == PHASE_W'(0))
                begin
                    scl = 1'b1;
                    sda = 1'b1;
                end
                else if (p == PHASE_W'(1)) scl = 1'b0;
                else sda = 1'b0;
            end
            CMD_WRITE, CMD_ADDR:
            begin
                if (p < BYTE_PHASES)
                begin
                    if (!p[0])
                    begin
                        scl = 1'b1;
                        sda = ~msb;
                    end
                    else scl = 1'b0;
                end
                else if (p == ACK_DRIVE_PHASE)
                begin
                    scl = 1'b1;
                    sda = 1'b0;
                end
                else if (p == LAST_BYTE_PHASE) scl = 1'b0;
                else if (p == RETRY_STOP_PHASE)
                begin
                    scl = 1'b1;
                    sda = 1'b1;
                end
                else if (p == RETRY_SCL_PHASE) scl = 1'b0;
                else if (p == RETRY_SDA_PHASE) sda = 1'b0;
                else sda = 1'b1;
            end
            CMD_READ:
            begin
                if (p < BYTE_PHASES)
                begin
                    if (!p[0])
                    begin
                        scl = 1'b1;
                        if (p == PHASE_W'(0)) sda = 1'b0;
                    end
                    else scl = 1'b0;
                end
                else if (p == ACK_DRIVE_PHASE)
                begin
                    scl = 1'b1;
                    sda = ack_low;
                end
                else scl = 1'b0;
            end
            default:
            begin
            end
        endcase
        return {scl, sda};
    endfunction

    assign load_val    = (half_period_ticks == '0) ? HALF_W'(1) : half_period_ticks;
    assign tick_dec    = tick_reg - HALF_W'(1);
    assign phase_adv   = phase_reg + PHASE_W'(1);
    assign busy        = (cmd_reg != CMD_IDLE);
    assign is_byte_cmd = (cmd_reg == CMD_WRITE) || (cmd_reg == CMD_ADDR);

    always_comb
    begin
        cmd_next    = cmd_reg;
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        tick_next   = tick_reg;
        retry_next  = retry_reg;
        start_phase = 1'b0;
        finish      = 1'b0;
        res_next    = '0;

        case (req_code_t'(item.req_type))
            REQ_TICK:
            begin
                if (busy)
                begin
                    tick_next = tick_dec;
                    if (tick_dec == '0)
                    begin
                        // SCL-high phase ending: shift one bit
                        if (phase_reg < BYTE_PHASES && phase_reg[0])
                        begin
                            if (is_byte_cmd)
                                shift_next = {shift_reg[BYTE_W-2:0], shift_reg[BYTE_W-1]};
                            else if (cmd_reg == CMD_READ)
                                shift_next = {shift_reg[BYTE_W-2:0], item.sda_in};
                        end
                        phase_next = phase_adv;
                        if (cmd_reg == CMD_ADDR && phase_reg == LAST_RETRY_PHASE)
                        begin
                            phase_next = '0;
                        end
                        else if (phase_reg == last_phase(cmd_reg))
                        begin
                            if (is_byte_cmd)
                            begin
                                if (cmd_reg == CMD_ADDR && retry_reg && item.sda_in)
                                    phase_next = RETRY_STOP_PHASE;
                                else
                                begin
                                    res_next.nack = item.sda_in;
                                    finish        = 1'b1;
                                end
                            end
                            else
                            begin
                                if (cmd_reg == CMD_READ) res_next.read_data = shift_next;
                                finish = 1'b1;
                            end
                        end
                        if (finish)
                        begin
                            res_next.done_res = 1'b1;
                            cmd_next          = CMD_IDLE;
                            phase_next        = '0;
                            tick_next         = '0;
                        end
                        else start_phase = 1'b1;
                    end
                end
            end
            REQ_START, REQ_REPSTART, REQ_STOP, REQ_WRITE, REQ_READ, REQ_ADDR:
            begin
                if (busy) res_next.rejected = 1'b1;
                else
                begin
                    phase_next  = '0;
                    retry_next  = 1'b0;
                    start_phase = 1'b1;
                    case (req_code_t'(item.req_type))
                        REQ_START:    cmd_next = CMD_START;
                        REQ_REPSTART: cmd_next = CMD_REPSTART;
                        REQ_STOP:     cmd_next = CMD_STOP;
                        REQ_WRITE:
                        begin
                            cmd_next   = CMD_WRITE;
                            shift_next = item.data_byte;
                        end
                        REQ_READ:
                        begin
                            cmd_next   = CMD_READ;
                            retry_next = item.send_ack;
                        end
                        REQ_ADDR:
                        begin
                            cmd_next   = CMD_ADDR;
                            shift_next = {item.target_address, item.read_not_write};
                            retry_next = item.retry_on_nack;
                        end
                        default:      cmd_next = cmd_reg;
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        drive    = phase_drive(cmd_next, phase_next, shift_next[BYTE_W-1], retry_next,
                               scl_reg, sda_reg);
        scl_next = start_phase ? drive[1] : scl_reg;
        sda_next = start_phase ? drive[0] : sda_reg;
        if (start_phase) tick_next = load_val;

        res_next.scl_low  = scl_next;
        res_next.sda_low  = sda_next;
        res_next.busy_res = (cmd_next != CMD_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= '0;
            shift_reg <= '0;
            tick_reg  <= '0;
            retry_reg <= 1'b0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
        end
        else if (step)
        begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            retry_reg <= retry_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

    // a running command always has a live phase timer
    a_busy_timer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg != CMD_IDLE |-> tick_reg != '0)
        else $error("busy with expired phase timer");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= LAST_RETRY_PHASE)
        else $error("phase out of range");

    // a rejected command leaves the sequence untouched
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_next.rejected |=> $stable(cmd_reg) && $stable(phase_reg)
            && $stable(tick_reg) && $stable(shift_reg))
        else $error("rejected command disturbed state");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        step && cmd_reg == CMD_IDLE && item.req_type == REQ_TICK
            |=> cmd_reg == CMD_IDLE && $stable(scl_reg) && $stable(sda_reg))
        else $error("idle tick changed bus");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_next.done_res |=> cmd_reg == CMD_IDLE && phase_reg == '0)
        else $error("done without returning idle");

endmodule

FILE: rtl/core/i2c_master_byte_sequencer.sv
// I2C master byte sequencer (open-drain, bit-banged).
// req channel: one beat per item. req_type 0 is a tick carrying the sampled
//   SDA level in sda_in; codes 1..6 are start, repeated start, stop, write
//   byte, read byte and address commands. A command is taken only while idle;
//   one that arrives while busy is answered with rejected and otherwise ignored.
// res channel: exactly one beat per req beat, in order, carrying the SCL/SDA
//   pull-down drivers, busy, done, nack and read_data.
// Latency: the result of a req beat is on res the cycle after it is taken.
// Throughput: one req beat per cycle unless a result is stalled; the
//   next-state logic sits between the accepted beat and the result register.
// Stall: the result register holds while a pending result waits on res.ready;
//   req.ready is high if none is held or it is taken in the same cycle.
// Config: APB register 0 (address 0) is half_period_ticks, the number of
//   ticks in each half-bit bus phase (0 acts as 1); reset value 40.
// Reset: both lines released, sequencer idle, no result pending.
module i2c_master_byte_sequencer
    import i2cms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    i2cms_req_if.sink          req,
    i2cms_res_if.source        res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [HALF_W-1:0] half_period_reg;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg;
    res_t              res_next;
    item_t             item;
    logic              accept;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_HALF_PERIOD);
    assign prdata    = (paddr[2] == REG_HALF_PERIOD)
                       ? PDATA_W'(half_period_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) half_period_reg <= HALF_PERIOD_RESET;
        else if (cfg_write) half_period_reg <= pwdata[HALF_W-1:0];
    end

    assign item.req_type       = req.req_type;
    assign item.sda_in         = req.sda_in;
    assign item.data_byte      = req.data_byte;
    assign item.target_address = req.target_address;
    assign item.read_not_write = req.read_not_write;
    assign item.send_ack       = req.send_ack;
    assign item.retry_on_nack  = req.retry_on_nack;

    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    i2cms_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (accept),
        .item              (item),
        .half_period_ticks (half_period_reg),
        .res_next          (res_next)
    );

    assign res_valid_next = accept || (res_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) res_valid_reg <= 1'b0;
        else res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept) res_reg <= res_next;
    end

    assign res.valid     = res_valid_reg;
    assign res.scl_low   = res_reg.scl_low;
    assign res.sda_low   = res_reg.sda_low;
    assign res.busy_res  = res_reg.busy_res;
    assign res.done_res  = res_reg.done_res;
    assign res.nack      = res_reg.nack;
    assign res.read_data = res_reg.read_data;
    assign res.rejected  = res_reg.rejected;

    a_every_beat_answered: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted beat produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |-> !accept)
        else $error("result overwritten while stalled");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> !res_reg.busy_res && !res_reg.rejected)
        else $error("done result marked busy or rejected");

endmodule
